/* src/urff_pkg.sv */
// urff_pkg: shared types and constants of the ultrasonic range frame filter
// status codes, register indexes, mode codes and register reset values
// no dependencies
package urff_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0]  START_BYTE = 8'hFF;
    localparam logic [15:0] SIM_TOL_MM = 16'd10;
    localparam logic [7:0]  STREAK_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_VALID   = 3'd0,
        REG_GUARD       = 3'd1,
        REG_MAX_VALID   = 3'd2,
        REG_MAX_STEP    = 3'd3,
        REG_REQUIRE     = 3'd4,
        REG_CLOSE_MODE  = 3'd5,
        REG_RAW_POLICY  = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CLOSE    = 3'd1,
        ST_FAR      = 3'd2,
        ST_CHECKSUM = 3'd3,
        ST_STEP     = 3'd4,
        ST_AWAIT    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        FP_HUNT = 2'd0,
        FP_HIGH = 2'd1,
        FP_LOW  = 2'd2,
        FP_SUM  = 2'd3
    } t_frame_pos;

    localparam logic [1:0] CLOSE_NAN  = 2'd0;
    localparam logic [1:0] CLOSE_MIN  = 2'd1;
    localparam logic [1:0] CLOSE_HOLD = 2'd2;

    localparam logic [1:0] RAW_OFF   = 2'd0;
    localparam logic [1:0] RAW_EVERY = 2'd1;
    localparam logic [1:0] RAW_VALID = 2'd2;

    localparam logic [15:0] RST_MIN_VALID  = 16'd280;
    localparam logic [15:0] RST_GUARD      = 16'd0;
    localparam logic [15:0] RST_MAX_VALID  = 16'd4500;
    localparam logic [15:0] RST_MAX_STEP   = 16'd0;
    localparam logic [7:0]  RST_REQUIRE    = 8'd1;
    localparam logic [1:0]  RST_CLOSE_MODE = CLOSE_NAN;
    localparam logic [1:0]  RST_RAW_POLICY = RAW_OFF;

    function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* src/ultrasonic_range_frame_filter_unit.sv */
// ultrasonic_range_frame_filter_unit: frame parser, range check, step check
// and confirmation filter for a byte stream from an ultrasonic sensor
// depends on urff_pkg
//
//   channel  direction  handshake           word
//   in       input      i_valid / o_stall   i_rx_byte
//   out      output     o_valid / i_stall   status, main and raw outputs
//   cfg      input      i_cfg_we            i_cfg_idx, i_cfg_data
//
// one byte per cycle unless stalled; a checksum byte produces its result in the
// output register at the accepting edge, so the result is valid in the cycle after it.
// the rate is set by the single compare-and-update pass on the state regs.
// synchronous active-low reset clears frame position, filter state and output valid, and loads regs with reset values.
// input is stalled only on a checksum byte while a result is still waiting.
module ultrasonic_range_frame_filter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_status,
    output logic                          o_main_publish,
    output logic                          o_main_valid,
    output logic [15:0]                   o_main_mm,
    output logic                          o_raw_publish,
    output logic                          o_raw_valid,
    output logic [15:0]                   o_raw_mm,
    input  logic                          i_cfg_we,
    input  logic [urff_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [urff_pkg::CFG_W-1:0]     i_cfg_data
);
    import urff_pkg::*;

    // configuration
    logic [15:0] r_min_valid, r_guard, r_max_valid, r_max_step;
    logic [7:0]  r_require;
    logic [1:0]  r_close_mode, r_raw_policy;

    // frame and filter state
    t_frame_pos  r_pos, n_pos;
    logic [7:0]  r_high, r_low;
    logic        r_lv_ok, n_lv_ok, r_lp_ok, n_lp_ok, r_cand_ok, n_cand_ok;
    logic [15:0] r_lv_mm, n_lv_mm, r_lp_mm, n_lp_mm, r_cand_mm, n_cand_mm;
    logic [7:0]  r_streak, n_streak;

    // output register
    logic        r_out_valid;
    t_status     r_status, n_status;
    logic        r_mp, n_mp, r_mv, n_mv, r_rp, n_rp, r_rv, n_rv;
    logic [15:0] r_mm, n_mm, r_rm, n_rm;

    logic        in_take, frame_end;
    logic [7:0]  sum_byte;
    logic [15:0] frame_mm, gmin;
    logic        sum_ok, near_band, too_far, step_bad, similar;
    logic [7:0]  streak_up;

    assign o_stall   = r_out_valid && i_stall && (r_pos == FP_SUM);
    assign in_take   = i_valid && !o_stall;
    assign frame_end = in_take && (r_pos == FP_SUM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_valid  <= RST_MIN_VALID;
            r_guard      <= RST_GUARD;
            r_max_valid  <= RST_MAX_VALID;
            r_max_step   <= RST_MAX_STEP;
            r_require    <= RST_REQUIRE;
            r_close_mode <= RST_CLOSE_MODE;
            r_raw_policy <= RST_RAW_POLICY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_VALID:  r_min_valid  <= i_cfg_data;
                REG_GUARD:      r_guard      <= i_cfg_data;
                REG_MAX_VALID:  r_max_valid  <= i_cfg_data;
                REG_MAX_STEP:   r_max_step   <= i_cfg_data;
                REG_REQUIRE:    r_require    <= i_cfg_data[7:0];
                REG_CLOSE_MODE: r_close_mode <= i_cfg_data[1:0];
                REG_RAW_POLICY: r_raw_policy <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // frame position sequencing
    always_comb begin
        n_pos = r_pos;
        unique case (r_pos)
            FP_HUNT: if (i_rx_byte == START_BYTE) n_pos = FP_HIGH;
            FP_HIGH: n_pos = FP_LOW;
            FP_LOW:  n_pos = FP_SUM;
            FP_SUM:  n_pos = FP_HUNT;
            default: n_pos = FP_HUNT;
        endcase
    end

    assign sum_byte  = START_BYTE + r_high + r_low;
    assign sum_ok    = (i_rx_byte == sum_byte);
    assign frame_mm  = {r_high, r_low};
    assign gmin      = r_min_valid + r_guard;
    assign near_band = (frame_mm <= r_min_valid) || (frame_mm < gmin);
    assign too_far   = (frame_mm >= r_max_valid);
    assign step_bad  = (r_max_step != 16'd0) && r_lp_ok &&
                       (abs_diff(frame_mm, r_lp_mm) > r_max_step);
    assign similar   = !r_cand_ok || (abs_diff(frame_mm, r_cand_mm) <= SIM_TOL_MM);
    assign streak_up = (r_streak < STREAK_MAX) ? (r_streak + 8'd1) : r_streak;

    // result of a completed frame and filter update
    always_comb begin
        n_lv_ok   = r_lv_ok;
        n_lv_mm   = r_lv_mm;
        n_lp_ok   = r_lp_ok;
        n_lp_mm   = r_lp_mm;
        n_cand_ok = r_cand_ok;
        n_cand_mm = r_cand_mm;
        n_streak  = r_streak;
        n_status  = ST_OK;
        n_mp      = 1'b0;
        n_mv      = 1'b0;
        n_mm      = 16'd0;
        n_rp      = 1'b0;
        n_rv      = 1'b0;
        n_rm      = 16'd0;
        if (!sum_ok) begin
            n_status = ST_CHECKSUM;
        end else begin
            if (r_raw_policy == RAW_EVERY) begin
                n_rp = 1'b1;
                n_rv = 1'b1;
                n_rm = frame_mm;
            end
            priority if (near_band || too_far) begin
                // raw goes out as nan under the valid-only policy
                if (r_raw_policy == RAW_VALID) n_rp = 1'b1;
                n_mp      = 1'b1;
                n_cand_ok = 1'b0;
                n_cand_mm = 16'd0;
                n_streak  = 8'd0;
                n_status  = near_band ? ST_CLOSE : ST_FAR;
                if (near_band) begin
                    priority if (r_close_mode == CLOSE_MIN) begin
                        n_mv    = 1'b1;
                        n_mm    = r_min_valid;
                        n_lv_ok = 1'b1;
                        n_lv_mm = r_min_valid;
                    end else if (r_close_mode == CLOSE_HOLD && r_lv_ok) begin
                        n_mv = 1'b1;
                        n_mm = r_lv_mm;
                    end else begin
                        n_mv = 1'b0;
                    end
                end
            end else if (step_bad) begin
                n_cand_ok = 1'b0;
                n_cand_mm = 16'd0;
                n_streak  = 8'd0;
                n_status  = ST_STEP;
            end else begin
                n_streak  = similar ? streak_up : 8'd1;
                n_cand_ok = 1'b1;
                n_cand_mm = frame_mm;
                if (n_streak < r_require) begin
                    n_status = ST_AWAIT;
                end else begin
                    n_mp      = 1'b1;
                    n_mv      = 1'b1;
                    n_mm      = frame_mm;
                    n_lv_ok   = 1'b1;
                    n_lv_mm   = frame_mm;
                    n_lp_ok   = 1'b1;
                    n_lp_mm   = frame_mm;
                    n_streak  = 8'd0;
                    n_cand_ok = 1'b0;
                    n_cand_mm = 16'd0;
                    if (r_raw_policy == RAW_VALID) begin
                        n_rp = 1'b1;
                        n_rv = 1'b1;
                        n_rm = frame_mm;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= FP_HUNT;
            r_high      <= 8'd0;
            r_low       <= 8'd0;
            r_lv_ok     <= 1'b0;
            r_lv_mm     <= 16'd0;
            r_lp_ok     <= 1'b0;
            r_lp_mm     <= 16'd0;
            r_cand_ok   <= 1'b0;
            r_cand_mm   <= 16'd0;
            r_streak    <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_pos <= n_pos;
                if (r_pos == FP_HIGH) r_high <= i_rx_byte;
                if (r_pos == FP_LOW)  r_low  <= i_rx_byte;
            end
            if (frame_end) begin
                r_lv_ok   <= n_lv_ok;
                r_lv_mm   <= n_lv_mm;
                r_lp_ok   <= n_lp_ok;
                r_lp_mm   <= n_lp_mm;
                r_cand_ok <= n_cand_ok;
                r_cand_mm <= n_cand_mm;
                r_streak  <= n_streak;
            end
            if (frame_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word, loaded only when the output register is free or draining
    always_ff @(posedge i_clk) begin
        if (frame_end) begin
            r_status <= n_status;
            r_mp     <= n_mp;
            r_mv     <= n_mv;
            r_mm     <= n_mm;
            r_rp     <= n_rp;
            r_rv     <= n_rv;
            r_rm     <= n_rm;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_main_publish = r_mp;
    assign o_main_valid   = r_mv;
    assign o_main_mm      = r_mm;
    assign o_raw_publish  = r_rp;
    assign o_raw_valid    = r_rv;
    assign o_raw_mm       = r_rm;

endmodule
